// File: sv/itf_pkg.sv
`default_nettype none

package itf_pkg;

  localparam int VALUE_W    = 64;
  localparam int NARROW_W   = 32;
  localparam int DIGITS     = 20;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int CNT_W      = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SKIP,
    B_SIGN,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic               hex;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_LOWER_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/integer_to_text_formatter.sv
`default_nettype none

// Formats one 64-bit word as ASCII text (signed decimal, unsigned decimal or lowercase
// hexadecimal, at 32 or 64 bits) and returns one character word per cycle while
// out_ready is high, most significant first, with last set on the final character.
// A two-entry queue sits between the input classifier and the converter, so new words
// are taken while a number is still being printed. A decimal number is first converted
// by bit-serial double dabble; leading zero digits are then skipped and the characters
// emitted; a hexadecimal number skips the conversion. The converter handles one number
// at a time.
module integer_to_text_formatter import itf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire logic               wide,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              char_code,
  output logic                    last
);

  job_t in_job;
  job_t q_job;
  logic q_full;
  logic q_nonempty;
  logic q_pop;

  assign in_ready = !q_full;

  itf_front u_front (
    .op    (op),
    .wide  (wide),
    .value (value),
    .job   (in_job)
  );

  itf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && !q_full),
    .push_job (in_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_job  (q_job)
  );

  itf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: sv/itf_front.sv
`default_nettype none

module itf_front import itf_pkg::*; (
  input  wire logic [1:0]         op,
  input  wire logic               wide,
  input  wire logic [VALUE_W-1:0] value,
  output job_t                    job
);

  logic [VALUE_W-1:0] v;
  logic [VALUE_W-1:0] neg_v;
  logic               sign;
  logic               is_dec;

  always_comb begin
    v      = wide ? value : {{(VALUE_W-NARROW_W){1'b0}}, value[NARROW_W-1:0]};
    sign   = wide ? value[VALUE_W-1] : value[NARROW_W-1];
    neg_v  = ~v + {{(VALUE_W-1){1'b0}}, 1'b1};
    is_dec = (op == OP_SDEC) || (op == OP_UDEC);
    job.hex = !is_dec;
    job.neg = (op == OP_SDEC) && sign;
    if (job.neg) begin
      job.mag = wide ? neg_v : {{(VALUE_W-NARROW_W){1'b0}}, neg_v[NARROW_W-1:0]};
    end else begin
      job.mag = v;
    end
  end

endmodule

`default_nettype wire

// File: sv/itf_queue.sv
`default_nettype none

module itf_queue import itf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      nonempty,
  output job_t      pop_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/itf_back.sv
`default_nettype none

module itf_back import itf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  input  wire job_t       job,
  output logic            job_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_code,
  output logic            last
);

  back_state_t          state;
  back_state_t          state_next;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [CNT_W-1:0]     cnt;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 neg;
  logic                 out_free;
  logic [3:0]           top_digit;
  logic                 start_hex;
  logic                 start_dec;
  logic                 conv_step;
  logic                 shift_digit;
  logic                 load_char;
  logic [7:0]           char_val;
  logic                 last_val;

  assign out_free  = !out_valid || out_ready;
  assign top_digit = bcd[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = job.hex ? B_SKIP : B_CONV;
        end
      end
      B_CONV: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = B_SKIP;
        end
      end
      B_SKIP: begin
        if (!(top_digit == 4'd0 && cnt > CNT_W'(1))) begin
          state_next = neg ? B_SIGN : B_EMIT;
        end
      end
      B_SIGN: begin
        if (out_free) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free && cnt == CNT_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop     = 1'b0;
    start_hex   = 1'b0;
    start_dec   = 1'b0;
    conv_step   = 1'b0;
    shift_digit = 1'b0;
    load_char   = 1'b0;
    char_val    = digit_char(top_digit);
    last_val    = (cnt == CNT_W'(1));
    case (state)
      B_IDLE: begin
        job_pop   = job_valid;
        start_hex = job_valid && job.hex;
        start_dec = job_valid && !job.hex;
      end
      B_CONV: begin
        conv_step = 1'b1;
      end
      B_SKIP: begin
        shift_digit = (top_digit == 4'd0) && (cnt > CNT_W'(1));
      end
      B_SIGN: begin
        load_char = out_free;
        char_val  = CHAR_MINUS;
        last_val  = 1'b0;
      end
      B_EMIT: begin
        load_char   = out_free;
        shift_digit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_hex) begin
      bcd <= {{(BCD_W-VALUE_W){1'b0}}, job.mag};
      neg <= job.neg;
      cnt <= CNT_W'(DIGITS);
    end else if (start_dec) begin
      bcd     <= '0;
      mag     <= job.mag;
      neg     <= job.neg;
      cnt     <= CNT_W'(DIGITS);
      bit_cnt <= '0;
    end else if (conv_step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end else if (shift_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
      cnt <= cnt - CNT_W'(1);
    end
    if (load_char) begin
      char_code <= char_val;
      last      <= last_val;
    end
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_char) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
